### rtl/bcmp_pkg.sv
// bcmp_pkg: shared types and constants for the binomial-mod-prime block.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps
package bcmp_pkg;

    localparam int unsigned W          = 30;
    localparam logic [W-1:0] P_MOD     = 30'd1000000007;
    localparam logic [W-1:0] P_EXP     = P_MOD - 30'd2;
    localparam int unsigned MAX_K_DEF  = 2047;
    // Barrett factor floor(2^60 / p), 31 bits
    localparam logic [63:0] MU_FULL    = (64'd1 << 60) / {34'd0, P_MOD};
    localparam logic [30:0] MU         = MU_FULL[30:0];

    typedef struct packed {
        logic [W-1:0] n_value;
        logic [W-1:0] k_value;
    } t_req;

    typedef struct packed {
        logic [W-1:0] binom;
        logic         range_error;
    } t_res;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_FILL_INIT,
        OP_RUN_MUL,
        OP_RUN_LOAD,
        OP_POW_MUL,
        OP_POW_ACC,
        OP_SQ_MUL,
        OP_SQ_LOAD,
        OP_TBL_WR,
        OP_REQ_LOAD,
        OP_REQ_PREP,
        OP_REQ_FAC,
        OP_PROD_MUL,
        OP_PROD_ACC,
        OP_TBL_RD,
        OP_FIN_MUL,
        OP_FIN_ACC,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic expo_zero;
        logic expo_bit0;
        logic fill_last;
        logic req_err;
        logic kk_zero;
        logic cnt_last;
    } t_sts;

endpackage

### rtl/bcmp_mulmod.sv
// bcmp_mulmod: 30x30 modular multiplier, Barrett reduction over four stages.
// Depends on bcmp_pkg.
`timescale 1ns / 1ps
module bcmp_mulmod (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [bcmp_pkg::W-1:0] i_a,
    input  logic [bcmp_pkg::W-1:0] i_b,
    output logic                 o_done,
    output logic [bcmp_pkg::W-1:0] o_y
);
    import bcmp_pkg::*;

    logic [2:0]  r_v;
    logic [59:0] r_x;
    logic [61:0] r_t;
    logic [31:0] r_r;
    logic [W-1:0] r_y;
    logic         r_done;
    logic [30:0] q;
    logic [61:0] qp;
    logic [31:0] p1, p2, n_y32;

    assign q  = r_t[61:31];
    assign qp = {31'd0, q} * {32'd0, P_MOD};
    assign p1 = {2'd0, P_MOD};
    assign p2 = {1'b0, P_MOD, 1'b0};

    // remainder is below 3p after the quotient estimate
    always_comb begin
        priority if (r_r >= p2) begin
            n_y32 = r_r - p2;
        end else if (r_r >= p1) begin
            n_y32 = r_r - p1;
        end else begin
            n_y32 = r_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= {r_v[1:0], i_start};
            r_done <= r_v[2];
        end
        if (i_start) begin
            r_x <= {30'd0, i_a} * {30'd0, i_b};
        end
        if (r_v[0]) begin
            r_t <= {31'd0, r_x[59:29]} * {31'd0, MU};
        end
        if (r_v[1]) begin
            r_r <= r_x[31:0] - qp[31:0];
        end
        if (r_v[2]) begin
            r_y <= n_y32[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;

    a_y_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_y < P_MOD)) else $error("mulmod result not reduced");

endmodule

### rtl/bcmp_dp.sv
// bcmp_dp: datapath: operand registers, inverse-factorial memory, mulmod unit.
// Depends on bcmp_pkg and bcmp_mulmod.
`timescale 1ns / 1ps
module bcmp_dp #(
    parameter int unsigned MAX_K = bcmp_pkg::MAX_K_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bcmp_pkg::t_cmd  i_cmd,
    input  bcmp_pkg::t_req  i_req,
    output bcmp_pkg::t_sts  o_sts,
    output logic            o_valid,
    output bcmp_pkg::t_res  o_res
);
    import bcmp_pkg::*;

    localparam int unsigned AW = $clog2(MAX_K + 1);

    logic [W-1:0] mem [0:MAX_K];

    logic [W-1:0]  r_n, r_k, r_kk, r_fac, r_acc, r_run, r_sq, r_pacc, r_expo, r_tbl_q;
    logic [AW-1:0] r_idx, r_cnt;
    logic          r_err, r_ready, r_valid;
    t_res          r_res;

    logic          mul_start, mul_done;
    logic [W-1:0]  mul_a, mul_b, mul_y;
    logic [W-1:0]  fac_red, nk, kk;
    logic          k_gt_n;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [W-1:0]  wr_data;

    assign fac_red = (r_fac >= P_MOD) ? (r_fac - P_MOD) : r_fac;
    assign k_gt_n  = r_k > r_n;
    assign nk      = r_n - r_k;
    assign kk      = (nk < r_k) ? nk : r_k;

    always_comb begin
        mul_start = 1'b1;
        mul_a     = r_acc;
        mul_b     = fac_red;
        unique case (i_cmd.op)
            OP_RUN_MUL:  begin mul_a = r_run;  mul_b = W'(r_idx); end
            OP_POW_MUL:  begin mul_a = r_pacc; mul_b = r_sq;      end
            OP_SQ_MUL:   begin mul_a = r_sq;   mul_b = r_sq;      end
            OP_PROD_MUL: begin mul_a = r_acc;  mul_b = fac_red;   end
            OP_FIN_MUL:  begin mul_a = r_acc;  mul_b = r_tbl_q;   end
            default:     mul_start = 1'b0;
        endcase
    end

    bcmp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_y     (mul_y)
    );

    always_comb begin
        wr_en   = (i_cmd.op == OP_FILL_INIT) || (i_cmd.op == OP_TBL_WR);
        wr_addr = (i_cmd.op == OP_FILL_INIT) ? '0 : r_idx;
        wr_data = (i_cmd.op == OP_FILL_INIT) ? W'(1) : r_pacc;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.op == OP_TBL_RD) begin
            r_tbl_q <= mem[r_kk[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_RESULT);
            if (i_cmd.op == OP_TBL_WR && r_idx == AW'(MAX_K)) begin
                r_ready <= 1'b1;
            end
        end
        unique case (i_cmd.op)
            OP_FILL_INIT: begin
                r_run <= W'(1);
                r_idx <= AW'(1);
            end
            OP_RUN_LOAD: begin
                r_run  <= mul_y;
                r_sq   <= mul_y;
                r_pacc <= W'(1);
                r_expo <= P_EXP;
            end
            OP_POW_ACC: r_pacc <= mul_y;
            OP_SQ_LOAD: begin
                r_sq   <= mul_y;
                r_expo <= r_expo >> 1;
            end
            OP_TBL_WR: r_idx <= r_idx + AW'(1);
            OP_REQ_LOAD: begin
                r_n   <= i_req.n_value;
                r_k   <= i_req.k_value;
                r_acc <= W'(1);
            end
            OP_REQ_PREP: begin
                r_kk  <= kk;
                r_err <= !r_ready || k_gt_n || (kk > W'(MAX_K));
            end
            OP_REQ_FAC: begin
                r_fac <= r_n - r_kk + W'(1);
                r_cnt <= r_kk[AW-1:0];
            end
            OP_PROD_ACC: begin
                r_acc <= mul_y;
                r_fac <= r_fac + W'(1);
                r_cnt <= r_cnt - AW'(1);
            end
            OP_FIN_ACC: r_acc <= mul_y;
            OP_RESULT: begin
                r_res.binom       <= r_err ? '0 : r_acc;
                r_res.range_error <= r_err;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.mul_done  = mul_done;
        o_sts.expo_zero = (r_expo == '0);
        o_sts.expo_bit0 = r_expo[0];
        o_sts.fill_last = (r_idx == AW'(MAX_K));
        o_sts.req_err   = r_err;
        o_sts.kk_zero   = (r_kk == '0);
        o_sts.cnt_last  = (r_cnt == AW'(1));
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.range_error) |-> (o_res.binom == '0))
        else $error("error result not zero");
    a_binom_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.binom < P_MOD)) else $error("result not reduced");

endmodule

### rtl/bcmp_ctrl.sv
// bcmp_ctrl: sequencer for table fill, exponentiation and request product.
// Depends on bcmp_pkg.
`timescale 1ns / 1ps
module bcmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  bcmp_pkg::t_sts  i_sts,
    output bcmp_pkg::t_cmd  o_cmd,
    output logic            busy
);
    import bcmp_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_RUN_MUL, S_RUN_WAIT, S_RUN_LOAD, S_POW_TEST,
        S_PMUL, S_PWAIT, S_PLOAD, S_SMUL, S_SWAIT, S_SLOAD, S_TBL_WR,
        S_IDLE, S_REQ_PREP, S_REQ_FAC, S_PRMUL, S_PRWAIT, S_PRLOAD,
        S_TRD, S_FMUL, S_FWAIT, S_FLOAD, S_RESULT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_INIT:     begin o_cmd.op = OP_FILL_INIT; n_state = S_RUN_MUL; end
            S_RUN_MUL:  begin o_cmd.op = OP_RUN_MUL;   n_state = S_RUN_WAIT; end
            S_RUN_WAIT: if (i_sts.mul_done) n_state = S_RUN_LOAD;
            S_RUN_LOAD: begin o_cmd.op = OP_RUN_LOAD;  n_state = S_POW_TEST; end
            S_POW_TEST: begin
                priority if (i_sts.expo_zero) n_state = S_TBL_WR;
                else if (i_sts.expo_bit0)     n_state = S_PMUL;
                else                          n_state = S_SMUL;
            end
            S_PMUL:     begin o_cmd.op = OP_POW_MUL;   n_state = S_PWAIT; end
            S_PWAIT:    if (i_sts.mul_done) n_state = S_PLOAD;
            S_PLOAD:    begin o_cmd.op = OP_POW_ACC;   n_state = S_SMUL; end
            S_SMUL:     begin o_cmd.op = OP_SQ_MUL;    n_state = S_SWAIT; end
            S_SWAIT:    if (i_sts.mul_done) n_state = S_SLOAD;
            S_SLOAD:    begin o_cmd.op = OP_SQ_LOAD;   n_state = S_POW_TEST; end
            S_TBL_WR: begin
                o_cmd.op = OP_TBL_WR;
                n_state  = i_sts.fill_last ? S_IDLE : S_RUN_MUL;
            end
            S_IDLE: if (start) begin
                o_cmd.op = OP_REQ_LOAD;
                n_state  = S_REQ_PREP;
            end
            S_REQ_PREP: begin o_cmd.op = OP_REQ_PREP;  n_state = S_REQ_FAC; end
            S_REQ_FAC: begin
                o_cmd.op = OP_REQ_FAC;
                priority if (i_sts.req_err) n_state = S_RESULT;
                else if (i_sts.kk_zero)     n_state = S_TRD;
                else                        n_state = S_PRMUL;
            end
            S_PRMUL:    begin o_cmd.op = OP_PROD_MUL;  n_state = S_PRWAIT; end
            S_PRWAIT:   if (i_sts.mul_done) n_state = S_PRLOAD;
            S_PRLOAD: begin
                o_cmd.op = OP_PROD_ACC;
                n_state  = i_sts.cnt_last ? S_TRD : S_PRMUL;
            end
            S_TRD:      begin o_cmd.op = OP_TBL_RD;    n_state = S_FMUL; end
            S_FMUL:     begin o_cmd.op = OP_FIN_MUL;   n_state = S_FWAIT; end
            S_FWAIT:    if (i_sts.mul_done) n_state = S_FLOAD;
            S_FLOAD:    begin o_cmd.op = OP_FIN_ACC;   n_state = S_RESULT; end
            S_RESULT:   begin o_cmd.op = OP_RESULT;    n_state = S_IDLE; end
            default:    n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_REQ_PREP)) else $error("start not taken");

endmodule

### rtl/binomial_coefficient_mod_prime.sv
// Binomial coefficient C(n,k) mod 1e9+7 using a table of inverse factorials.
// Reset: synchronous i_rst_n; afterwards a fill pass builds the table, busy high.
// Fill: 46 modular multiplies per table entry above 0 (Fermat power), all run
//   on the shared mulmod unit.
// Request: one transaction at a time; min(k,n-k) product multiplies, one table multiply,
//   then o_valid (range error: none); next start taken in the strobe cycle; no receiver stall.
`timescale 1ns / 1ps
module binomial_coefficient_mod_prime #(
    parameter int unsigned MAX_K = bcmp_pkg::MAX_K_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  bcmp_pkg::t_req i_req,
    output logic           busy,
    output logic           o_valid,
    output bcmp_pkg::t_res o_res
);
    import bcmp_pkg::*;

    // controller/datapath handshake
    t_cmd cmd;
    t_sts sts;

    // sequencer: fill pass after reset, then one request transaction at a time
    bcmp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // datapath: table memory, running factorial, power, product, result register
    bcmp_dp #(
        .MAX_K (MAX_K)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

### tb/sv/binomial_coefficient_mod_prime_test.sv
// Self-checking testbench for binomial_coefficient_mod_prime: C(n,k) mod 1e9+7.
// Depends on rtl/bcmp_pkg.sv and rtl/binomial_coefficient_mod_prime.sv.
// Builds its own inverse-factorial table and checks each result against it.
`timescale 1ns / 1ps
module binomial_coefficient_mod_prime_test;
    import bcmp_pkg::*;

    localparam int unsigned TBL_MAX   = MAX_K_DEF;
    localparam logic [W-1:0] N_ALL1   = {W{1'b1}};
    // No transaction for this many cycles ends the run; covers the start-up fill
    localparam int unsigned QUIET_MAX = 3000000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_valid;
    t_res o_res;

    binomial_coefficient_mod_prime DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always #6 i_clk = ~i_clk;

    // Golden inverse factorials, entry i = (i!)^-1 mod p
    logic [W-1:0] inv_fact [0:TBL_MAX];
    t_res         binom_queue[$];
    int unsigned  mismatches;
    int unsigned  sent_cnt;
    int unsigned  checked_cnt;
    int unsigned  error_cnt;
    int unsigned  quiet_cycles;
    int unsigned  gap_pct;     // chance (percent) that the sender idles after a transaction

    function automatic logic [W-1:0] mul_mod(input longint unsigned a, input longint unsigned b);
        return W'((a * b) % longint'(P_MOD));
    endfunction

    function automatic logic [W-1:0] pow_mod(input logic [W-1:0] base, input logic [W-1:0] e);
        logic [W-1:0] acc;
        logic [W-1:0] sq;
        acc = 1;
        sq  = W'(longint'(base) % longint'(P_MOD));
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, sq);
            e  = e >> 1;
            sq = mul_mod(sq, sq);
        end
        return acc;
    endfunction

    task automatic build_inv_fact();
        logic [W-1:0] running;
        running     = 1;
        inv_fact[0] = 1;
        for (int unsigned i = 1; i <= TBL_MAX; i++) begin
            running     = mul_mod(running, i);
            inv_fact[i] = pow_mod(running, P_EXP);
        end
    endtask

    // Expected result: falling product of kk terms (each reduced mod p) times inv(kk!)
    function automatic t_res predict_binom(input logic [W-1:0] n, input logic [W-1:0] k);
        t_res         r;
        logic [W-1:0] kk;
        logic [W-1:0] acc;
        r = '{binom: '0, range_error: 1'b1};
        if (k > n) return r;
        kk = (n - k < k) ? n - k : k;
        if (kk > TBL_MAX) return r;
        acc = 1;
        for (longint unsigned i = longint'(n) - kk + 1; i <= n; i++)
            acc = mul_mod(acc, i % longint'(P_MOD));
        r.binom       = mul_mod(acc, inv_fact[kk]);
        r.range_error = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        mismatches++;
        $display("MISMATCH @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Drive one request; hold start until accepted, then maybe idle.
    // start stays high when no gap follows so the next transaction runs back to back.
    task automatic post_request(input logic [W-1:0] n, input logic [W-1:0] k);
        int unsigned gap;
        t_res        want;
        start <= 1'b1;
        i_req <= '{n_value: n, k_value: k};
        do @(posedge i_clk); while (busy);
        want = predict_binom(n, k);
        binom_queue.push_back(want);
        sent_cnt++;
        if (want.range_error) error_cnt++;
        if ($urandom_range(99) < gap_pct) begin
            gap = $urandom_range(1, 25);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender holds off until every outstanding result is back
    task automatic wait_drained();
        @(posedge i_clk);
        start <= 1'b0;
        while (binom_queue.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Random request with mostly small reduced k; n spans all 30 bits
    task automatic post_random(input int unsigned kk_hi);
        logic [W-1:0] n;
        logic [W-1:0] kk;
        int unsigned  pick;
        pick = $urandom_range(99);
        n    = (pick < 15) ? W'($urandom_range(0, 300)) : W'($urandom);
        kk   = W'($urandom_range(0, kk_hi));
        if (pick >= 90)
            post_request(n, (n == N_ALL1) ? n : n + W'($urandom_range(1, 1000)));  // mostly k above n
        else if (kk > n)
            post_request(n, n);
        else
            post_request(n, ($urandom_range(1)) ? kk : n - kk);
    endtask

    // Result checker: a result is on the ports for one cycle only
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (binom_queue.size() == 0) begin
                report_mismatch("result with none outstanding, binom", o_res.binom, '0);
            end else begin
                t_res want;
                want = binom_queue.pop_front();
                checked_cnt++;
                if (o_res.binom !== want.binom)
                    report_mismatch("binom", o_res.binom, want.binom);
                if (o_res.range_error !== want.range_error)
                    report_mismatch("range_error", W'(o_res.range_error), W'(want.range_error));
            end
        end
    end

    // Watchdog: counts cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("Timeout after %0d idle cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_edges();
        post_request(0, 0);
        post_request(5, 0);
        post_request(5, 5);                     // k equal to n
        post_request(10, 3);
        post_request(10, 7);
        post_request(100, 50);
        post_request(2047, 1024);
        post_request(N_ALL1, 0);
        post_request(N_ALL1, 1);
        post_request(N_ALL1, W'(N_ALL1 - 1));
        post_request(N_ALL1, N_ALL1);
        post_request(P_MOD, 1);                 // n at the modulus, factor reduces to zero
        post_request(W'(P_MOD + 5), 3);         // n above the modulus, no Lucas correction
        post_request(W'(P_MOD - 1), 2);
        post_request(W'(P_MOD - 1), W'(TBL_MAX));       // largest reduced k that fits
        post_request(W'(P_MOD - 1), W'(P_MOD - 1 - TBL_MAX));
        wait_drained();
    endtask

    task automatic test_range_errors();
        post_request(3, 5);                     // k above n
        post_request(0, 1);
        post_request(0, N_ALL1);
        post_request(5000, W'(TBL_MAX + 1));    // reduced k beyond table
        post_request(W'(P_MOD - 1), W'((P_MOD - 1) / 2));
        post_request(W'(N_ALL1 - 1), N_ALL1);
        wait_drained();
    endtask

    task automatic test_random(input int unsigned count, input int unsigned kk_hi);
        repeat (count) post_random(kk_hi);
    endtask

    task automatic test_large_k();
        repeat (3) post_request(W'($urandom) | W'(1 << 29), W'($urandom_range(1500, TBL_MAX)));
        post_request(W'($urandom_range(TBL_MAX + 1, 100000)),
                     W'(TBL_MAX + 1 + $urandom_range(9)));
        wait_drained();
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        mismatches   = 0;
        sent_cnt     = 0;
        checked_cnt  = 0;
        error_cnt    = 0;
        quiet_cycles = 0;
        gap_pct      = 0;
        build_inv_fact();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Table fill runs with busy high; post_request waits it out
        test_edges();
        test_range_errors();
        test_random(90, 40);
        gap_pct = 57;
        test_random(80, 40);
        wait_drained();
        gap_pct = 9;
        test_random(80, 200);
        test_large_k();
        gap_pct = 0;
        test_random(30, 12);

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d requests (%0d range errors), %0d results checked,",
                 sent_cnt, error_cnt, checked_cnt);
        $display("with n over all 30 bits, reduced k up to the table end, and sender gaps.");
        if (mismatches == 0 && binom_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, binom_queue.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### binomial_coefficient_mod_prime.f
rtl/bcmp_pkg.sv
rtl/bcmp_mulmod.sv
rtl/bcmp_dp.sv
rtl/bcmp_ctrl.sv
rtl/binomial_coefficient_mod_prime.sv
tb/sv/binomial_coefficient_mod_prime_test.sv
